[src/ajbc_pkg.sv]
// ----------------------------------------------------------------------------
// ajbc_pkg: shared types and constants of the jitter buffer playout controller
// Holds the register map, the reset values, the playout action codes and the
// structs that pass configuration and results between the modules.
// ----------------------------------------------------------------------------
package ajbc_pkg;

   // Queue capacity in frames (legal range 8 to 255).
   localparam int QueueCapDefault = 31;

   // Configuration port geometry.
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 16;

   // Stream payload widths, padded to whole bytes.
   localparam int ReqDataW = 40;
   localparam int RspDataW = 24;

   // Register reset values.
   localparam logic [3:0]  PrebufMinReset     = 4'd3;
   localparam logic [3:0]  PrebufMaxReset     = 4'd8;
   localparam logic [3:0]  ConcealMaxRunReset = 4'd5;
   localparam logic [15:0] CalmMsReset        = 16'd5000;
   localparam logic [15:0] StaleMsReset       = 16'd700;
   localparam logic [3:0]  TrimAboveReset     = 4'd9;
   localparam logic [3:0]  TrimKeepReset      = 4'd3;
   localparam logic [3:0]  LockAfterReset     = 4'd3;

   // Saturation point of the decrypt failure counter.
   localparam logic [3:0] FailCountMax = 4'd15;

   // Step by which one concealment run raises the prebuffer target.
   localparam logic [4:0] PrebufRaise = 5'd2;

   // Largest value the 5-bit count outputs can show.
   localparam int LevelOutMax = 31;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_PREBUF_MIN      = 3'd0,
      CSR_PREBUF_MAX      = 3'd1,
      CSR_CONCEAL_MAX_RUN = 3'd2,
      CSR_CALM_MS         = 3'd3,
      CSR_STALE_MS        = 3'd4,
      CSR_TRIM_ABOVE      = 3'd5,
      CSR_TRIM_KEEP       = 3'd6,
      CSR_LOCK_AFTER      = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_SILENT  = 2'd0,
      ACT_PLAY    = 2'd1,
      ACT_CONCEAL = 2'd2,
      ACT_STOP    = 2'd3
   } action_type;

   // Item kinds carried in the request tuser bit.
   localparam logic ModeArrival = 1'b0;

   typedef struct packed {
      logic [3:0]  prebuf_min;
      logic [3:0]  prebuf_max;
      logic [3:0]  conceal_max_run;
      logic [15:0] calm_ms;
      logic [15:0] stale_ms;
      logic [3:0]  trim_above;
      logic [3:0]  trim_keep;
      logic [3:0]  lock_after;
   } cfg_type;

   typedef struct packed {
      action_type  play_action;
      logic        accept_frame;
      logic [4:0]  drop_count;
      logic        is_locked;
      logic        lock_changed;
      logic [4:0]  queue_level;
      logic [3:0]  prebuf_level;
      logic        is_playing;
   } result_type;

endpackage

[src/ajbc_csr.sv]
// ----------------------------------------------------------------------------
// ajbc_csr: configuration registers
// Eight write-only registers, loaded from the plain write port and presented
// to the core as one struct.
// ----------------------------------------------------------------------------
module ajbc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [ajbc_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [ajbc_pkg::CsrDataW-1:0]   csr_wdata,
   output ajbc_pkg::cfg_type               cfg
);

   ajbc_pkg::cfg_type cfg_ff;
   ajbc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (ajbc_pkg::csr_index_type'(csr_index))
            ajbc_pkg::CSR_PREBUF_MIN:      cfg_in.prebuf_min      = csr_wdata[3:0];
            ajbc_pkg::CSR_PREBUF_MAX:      cfg_in.prebuf_max      = csr_wdata[3:0];
            ajbc_pkg::CSR_CONCEAL_MAX_RUN: cfg_in.conceal_max_run = csr_wdata[3:0];
            ajbc_pkg::CSR_CALM_MS:         cfg_in.calm_ms         = csr_wdata[15:0];
            ajbc_pkg::CSR_STALE_MS:        cfg_in.stale_ms        = csr_wdata[15:0];
            ajbc_pkg::CSR_TRIM_ABOVE:      cfg_in.trim_above      = csr_wdata[3:0];
            ajbc_pkg::CSR_TRIM_KEEP:       cfg_in.trim_keep       = csr_wdata[3:0];
            ajbc_pkg::CSR_LOCK_AFTER:      cfg_in.lock_after      = csr_wdata[3:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prebuf_min      <= ajbc_pkg::PrebufMinReset;
         cfg_ff.prebuf_max      <= ajbc_pkg::PrebufMaxReset;
         cfg_ff.conceal_max_run <= ajbc_pkg::ConcealMaxRunReset;
         cfg_ff.calm_ms         <= ajbc_pkg::CalmMsReset;
         cfg_ff.stale_ms        <= ajbc_pkg::StaleMsReset;
         cfg_ff.trim_above      <= ajbc_pkg::TrimAboveReset;
         cfg_ff.trim_keep       <= ajbc_pkg::TrimKeepReset;
         cfg_ff.lock_after      <= ajbc_pkg::LockAfterReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/ajbc_core.sv]
// ----------------------------------------------------------------------------
// ajbc_core: playout state and single-pass update
// Holds the queue count, prebuffer target, lock and timing state, and works
// out the next state and the result of one item combinationally.
// ----------------------------------------------------------------------------
module ajbc_core #(
   parameter int QUEUE_CAP = ajbc_pkg::QueueCapDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   mode,
   input  logic [31:0]            now_ms,
   input  logic                   open_failed,
   input  logic                   decode_bad,
   input  ajbc_pkg::cfg_type      cfg,
   output ajbc_pkg::result_type   result
);

   localparam int QW = $clog2(QUEUE_CAP + 1);
   // Working width for counts and sums: holds QUEUE_CAP + 1 and target + 15.
   localparam int CW = QW + 2;
   localparam logic [CW-1:0] CapW   = CW'(QUEUE_CAP);
   localparam logic [CW-1:0] OutMax = CW'(ajbc_pkg::LevelOutMax);

   logic [QW-1:0] queued_ff,   queued_in;
   logic [3:0]    target_ff,   target_in;
   logic          playing_ff,  playing_in;
   logic [3:0]    run_ff,      run_in;
   logic [31:0]   calm_ff,     calm_in;
   logic [31:0]   arrival_ff,  arrival_in;
   logic          dec_ready_ff, dec_ready_in;
   logic [3:0]    fail_ff,     fail_in;
   logic          locked_ff,   locked_in;

   ajbc_pkg::action_type action;
   logic                 accept;
   logic [CW-1:0]        drop;
   logic [CW-1:0]        count;
   logic [CW-1:0]        trim_limit;
   logic [CW-1:0]        keep;
   logic [CW-1:0]        kept;
   logic [CW-1:0]        queue_ext;
   logic [4:0]           raised;
   logic                 go;

   always_comb begin
      queued_in    = queued_ff;
      target_in    = target_ff;
      playing_in   = playing_ff;
      run_in       = run_ff;
      calm_in      = calm_ff;
      arrival_in   = arrival_ff;
      dec_ready_in = dec_ready_ff;
      fail_in      = fail_ff;
      locked_in    = locked_ff;
      action       = ajbc_pkg::ACT_SILENT;
      accept       = 1'b0;
      drop         = '0;
      go           = 1'b1;
      count        = CW'(queued_ff) + CW'(1);
      trim_limit   = CW'(target_ff) + CW'(cfg.trim_above);
      keep         = CW'(target_ff) + CW'(cfg.trim_keep);
      kept         = count;
      raised       = 5'(target_ff) + ajbc_pkg::PrebufRaise;

      if (mode == ajbc_pkg::ModeArrival) begin
         if (open_failed) begin
            if (fail_ff != ajbc_pkg::FailCountMax) begin
               fail_in = fail_ff + 4'd1;
            end
            if (fail_in >= cfg.lock_after) begin
               locked_in = 1'b1;
            end
         end else begin
            fail_in      = '0;
            locked_in    = 1'b0;
            dec_ready_in = 1'b1;
            if (!decode_bad) begin
               accept     = 1'b1;
               arrival_in = now_ms;
               if (count > trim_limit && keep < count) begin
                  drop = count - keep;
               end
               kept = count - drop;
               // A full queue sheds extra head frames down to the capacity.
               if (kept > CapW) begin
                  drop = count - CapW;
                  kept = CapW;
               end
               queued_in = QW'(kept);
            end
         end
      end else begin
         if (!playing_ff) begin
            if (CW'(queued_ff) >= CW'(target_ff)) begin
               playing_in = 1'b1;
               run_in     = '0;
               calm_in    = now_ms;
            end else begin
               go = 1'b0;
            end
         end
         if (go) begin
            if (queued_ff != '0) begin
               queued_in = queued_ff - QW'(1);
               run_in    = '0;
               action    = ajbc_pkg::ACT_PLAY;
               if (target_ff > cfg.prebuf_min &&
                   (now_ms - calm_in) > 32'(cfg.calm_ms)) begin
                  target_in = target_ff - 4'd1;
                  calm_in   = now_ms;
               end
            end else if (!dec_ready_ff || run_in >= cfg.conceal_max_run ||
                         (now_ms - arrival_ff) > 32'(cfg.stale_ms)) begin
               playing_in = 1'b0;
               action     = ajbc_pkg::ACT_STOP;
            end else begin
               // Only the first gap of a run widens the prebuffer.
               if (run_in == 4'd0) begin
                  target_in = (raised < 5'(cfg.prebuf_max)) ? raised[3:0]
                                                            : cfg.prebuf_max;
                  calm_in   = now_ms;
               end
               run_in = run_in + 4'd1;
               action = ajbc_pkg::ACT_CONCEAL;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queued_ff    <= '0;
         target_ff    <= ajbc_pkg::PrebufMinReset;
         playing_ff   <= 1'b0;
         run_ff       <= '0;
         calm_ff      <= '0;
         arrival_ff   <= '0;
         dec_ready_ff <= 1'b0;
         fail_ff      <= '0;
         locked_ff    <= 1'b0;
      end else if (step) begin
         queued_ff    <= queued_in;
         target_ff    <= target_in;
         playing_ff   <= playing_in;
         run_ff       <= run_in;
         calm_ff      <= calm_in;
         arrival_ff   <= arrival_in;
         dec_ready_ff <= dec_ready_in;
         fail_ff      <= fail_in;
         locked_ff    <= locked_in;
      end
   end

   assign queue_ext = CW'(queued_in);

   always_comb begin
      result.play_action  = action;
      result.accept_frame = accept;
      result.drop_count   = (drop > OutMax) ? 5'(ajbc_pkg::LevelOutMax) : drop[4:0];
      result.is_locked    = locked_in;
      result.lock_changed = (mode == ajbc_pkg::ModeArrival) && (locked_in != locked_ff);
      result.queue_level  = (queue_ext > OutMax) ? 5'(ajbc_pkg::LevelOutMax)
                                                 : queue_ext[4:0];
      result.prebuf_level = target_in;
      result.is_playing   = playing_in;
   end

endmodule

[src/adaptive_jitter_buffer_control.sv]
// ----------------------------------------------------------------------------
// adaptive_jitter_buffer_control: jitter buffer playout controller
// Counts queued frames of one audio stream, tracks decrypt lock, trims the
// queue on arrival and picks silence, play, conceal or stop per playout tick.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_tvalid/req_tready  tuser mode, tdata fields
//   rsp_      out        rsp_tvalid/rsp_tready  tdata result fields
//   csr_      in         csr_wr_en              csr_index, csr_wdata
//
// Each item is held in the input register and is resolved into the result
// register once that is free or rsp_tready is high, so one item is taken
// every cycle while results drain. The input register refills while a
// result waits, so throughput drops only when rsp_tready is held low. Reset
// is synchronous and needs no clearing time.
// ----------------------------------------------------------------------------
module adaptive_jitter_buffer_control #(
   parameter int QUEUE_CAP = ajbc_pkg::QueueCapDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input items
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: now_ms[31:0], open_failed[32], decode_bad[33], zero[39:34]
   input  logic [ajbc_pkg::ReqDataW-1:0]   req_tdata,
   // tuser: mode[0] (0 arrival, 1 playout tick)
   input  logic                            req_tuser,
   // Result items
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: play_action[1:0], accept_frame[2], drop_count[7:3], is_locked[8],
   //        lock_changed[9], queue_level[14:10], prebuf_level[18:15],
   //        is_playing[19], zero[23:20]
   output logic [ajbc_pkg::RspDataW-1:0]   rsp_tdata,
   // Configuration writes
   input  logic                            csr_wr_en,
   input  logic [ajbc_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [ajbc_pkg::CsrDataW-1:0]   csr_wdata
);

   ajbc_pkg::cfg_type    cfg;
   ajbc_pkg::result_type result;

   logic        st_valid_ff, st_valid_in;
   logic        st_mode_ff;
   logic [31:0] st_now_ff;
   logic        st_open_ff;
   logic        st_bad_ff;
   logic        out_valid_ff, out_valid_in;
   logic [ajbc_pkg::RspDataW-1:0] out_data_ff;
   logic        advance;
   logic        req_take;

   assign advance    = st_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !st_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      st_valid_in = st_valid_ff;
      if (req_take) begin
         st_valid_in = 1'b1;
      end else if (advance) begin
         st_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         st_valid_ff  <= st_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         st_mode_ff <= req_tuser;
         st_now_ff  <= req_tdata[31:0];
         st_open_ff <= req_tdata[32];
         st_bad_ff  <= req_tdata[33];
      end
      if (advance) begin
         out_data_ff <= {4'b0000, result.is_playing, result.prebuf_level,
                         result.queue_level, result.lock_changed, result.is_locked,
                         result.drop_count, result.accept_frame, result.play_action};
      end
   end

   ajbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ajbc_core #(
      .QUEUE_CAP (QUEUE_CAP)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .mode        (st_mode_ff),
      .now_ms      (st_now_ff),
      .open_failed (st_open_ff),
      .decode_bad  (st_bad_ff),
      .cfg         (cfg),
      .result      (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
